@@ rtl/core/afpe_pkg.sv @@
// afpe_pkg: shared types and constants of the alloc/free pair eliminator
// used by afpe_front, afpe_back and the top level
package afpe_pkg;
  localparam logic       CMD_RECORD = 1'b0;
  localparam logic       CMD_FLUSH  = 1'b1;
  localparam logic [0:0] REG_LIMIT  = 1'b0;
  localparam logic [0:0] REG_MAXREC = 1'b1;
  localparam logic [31:0] FREE_MARK = 32'hFFFF_FFFF;
  localparam logic [5:0]  LIMIT_RESET  = 6'd32;
  localparam logic [31:0] MAXREC_RESET = 32'd5000000;
  // event counts and slots, enough for up to 64 buffered events
  localparam int CNT_W = 7;

  typedef struct packed {
    logic [63:0] address;
    logic [30:0] stamp;
    logic [31:0] size;
    logic [30:0] trace;
  } event_t;

  // front to back: store an event, run a compaction over count events, or both
  typedef struct packed {
    logic             store;
    logic             compact;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] count;
    event_t           ev;
  } job_t;
endpackage

@@ rtl/core/afpe_front.sv @@
// afpe_front: accepts input words, drops records while stopped, tracks fill,
// decides when a compaction is due and queues jobs; depends on afpe_pkg
module afpe_front import afpe_pkg::*; #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  event_t      in_ev,
  input  logic [5:0]  limit,
  input  logic        clear_fill,
  input  logic        hold,
  input  logic        stopped,
  input  logic        back_done,
  output logic        empty,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_inc;
  logic [CNT_W-1:0] eff_limit;
  logic             cmp_out;
  job_t             q [2];
  logic             wp, rp;
  logic [1:0]       qcnt;
  logic             acc, push, pop;
  job_t             new_job;

  // while a compaction is outstanding the stop flag may still change
  assign in_ready = (qcnt != 2'd2) && !cmp_out && !hold;
  assign acc = in_valid && in_ready;
  assign fill_inc = fill + CNT_W'(1);
  assign job_valid = (qcnt != 2'd0);
  assign job = q[rp];
  assign pop = job_valid && job_ready;
  assign empty = (qcnt == 2'd0);

  always_comb begin
    if (limit == 6'd0) eff_limit = CNT_W'(1);
    else if ({1'b0, limit} > CNT_W'(BUFFER_DEPTH)) eff_limit = CNT_W'(BUFFER_DEPTH);
    else eff_limit = {1'b0, limit};
  end

  always_comb begin
    new_job = '0;
    new_job.ev = in_ev;
    new_job.slot = fill;
    push = 1'b0;
    if (acc) begin
      if (in_command == CMD_FLUSH) begin
        push = 1'b1;
        new_job.compact = 1'b1;
        new_job.count = fill;
      end else if (!stopped) begin
        push = 1'b1;
        new_job.store = 1'b1;
        new_job.compact = (fill_inc >= eff_limit);
        new_job.count = fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      cmp_out <= 1'b0;
      wp <= 1'b0;
      rp <= 1'b0;
      qcnt <= 2'd0;
    end else begin
      if (clear_fill || (push && new_job.compact)) fill <= '0;
      else if (push) fill <= fill_inc;
      if (push && new_job.compact) cmp_out <= 1'b1;
      else if (back_done) cmp_out <= 1'b0;
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      qcnt <= qcnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= new_job;
  end
endmodule

@@ rtl/core/afpe_back.sv @@
// afpe_back: event buffer and compaction sequencer, compares one pair of
// entries per cycle, waits while the output is full; depends on afpe_pkg
module afpe_back import afpe_pkg::*; #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  input  logic [31:0] max_records,
  output logic        busy,
  output logic        stopped,
  output logic        done,
  output logic        out_valid,
  input  logic        out_ready,
  output event_t      out_ev,
  output logic        out_last
);
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_RDI = 3'd1, S_SCAN = 3'd2,
                         S_DEC = 3'd3, S_FIN = 3'd4;
  event_t mem [BUFFER_DEPTH];
  event_t           rd_i;
  logic [63:0]      rd_j;
  logic [2:0]       state;
  logic [CNT_W-1:0] n, i, j, jd, cnt;
  logic             cmp_v, first, latest, keep, out_free, emit, finish;
  logic [31:0]      total;
  logic [32:0]      sum;
  logic [31:0]      total_next;
  // held kept event waits until the next kept one or the end to know last
  event_t           held;
  logic             held_v;

  assign busy = (state != S_IDLE);
  assign job_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign keep = (first && latest) || (first && rd_i.size == FREE_MARK) ||
                (latest && rd_i.size != 32'd0 && !rd_i.size[31]);
  assign emit = out_free && held_v && ((state == S_DEC && keep) || state == S_FIN);
  assign finish = (state == S_FIN) && (!held_v || out_free);
  assign done = finish;
  assign sum = {1'b0, total} + {26'd0, cnt};
  assign total_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  always_ff @(posedge clk) begin
    if (job_valid && job_ready && job.store) mem[job.slot[AW-1:0]] <= job.ev;
    rd_i <= mem[i[AW-1:0]];
    rd_j <= mem[j[AW-1:0]].address;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; total <= '0; stopped <= 1'b0; out_valid <= 1'b0;
      held_v <= 1'b0; n <= '0; i <= '0; j <= '0; jd <= '0; cnt <= '0;
      cmp_v <= 1'b0; first <= 1'b0; latest <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (job_valid && job.compact) begin
            n <= job.count; i <= '0; cnt <= '0; held_v <= 1'b0;
            state <= S_RDI;
          end
        end
        S_RDI: begin
          j <= '0; cmp_v <= 1'b0; first <= 1'b1; latest <= 1'b1;
          state <= (i >= n) ? S_FIN : S_SCAN;
        end
        S_SCAN: begin
          // rd_j holds entry jd, read at the previous value of the read address j
          if (cmp_v && jd != i && rd_j == rd_i.address) begin
            if (jd < i) first <= 1'b0;
            else latest <= 1'b0;
          end
          if (j < n) begin
            jd <= j; j <= j + CNT_W'(1); cmp_v <= 1'b1;
          end else begin
            cmp_v <= 1'b0; state <= S_DEC;
          end
        end
        S_DEC: begin
          if (!(keep && held_v) || out_free) begin
            if (keep) begin
              held_v <= 1'b1; cnt <= cnt + CNT_W'(1);
            end
            i <= i + CNT_W'(1); state <= S_RDI;
          end
        end
        S_FIN: begin
          if (finish) begin
            held_v <= 1'b0;
            total <= total_next;
            if (total_next >= max_records) stopped <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ev <= held;
      out_last <= (state == S_FIN);
    end
    if (state == S_DEC && keep && (!held_v || out_free)) held <= rd_i;
  end
endmodule

@@ rtl/core/alloc_free_pair_eliminator_unit.sv @@
// alloc_free_pair_eliminator_unit: top level, config registers, front and back
// depends on afpe_pkg, afpe_front, afpe_back
//
// input words on s_t*: s_tuser 0 records an event, 1 flushes the buffer now.
// kept events leave on m_t* in arrival order, m_tlast on the final word of a
// compaction. config writes on cfg_*: index 0 buffer limit (clears the
// buffer), index 1 max records; cfg_ready is high only while the block is
// idle, and a pending write holds s_tready low until then.
// a record word below the limit is accepted every cycle unless a compaction
// or config write is pending, and enters the buffer as it leaves the queue.
// the word that triggers a compaction of n events (limit reached, or a
// flush) holds s_tready low until the pass ends: the pass compares one pair
// per cycle. a kept word leaves when the next kept one is found or at the
// end of the pass.
// receiver stall: one output register; the pass waits while it is full.
// reset: buffer empty, limit 32, max records 5000000, stop flag cleared.
module alloc_free_pair_eliminator_unit import afpe_pkg::*; #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,  // address[63:0], stamp[94:64], byte_count, trace_id
  input  logic         s_tuser,  // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,  // out_address, out_stamp, out_byte_count, out_trace_id
  output logic         m_tlast,  // last
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  logic [5:0]  limit;
  logic [31:0] max_records;
  logic        cfg_acc, clear_fill, front_empty, back_busy, stopped, back_done;
  logic        job_valid, job_ready;
  job_t        job;
  event_t      in_ev, out_ev;

  assign cfg_ready = front_empty && !back_busy;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign clear_fill = cfg_acc && (cfg_index == REG_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
      max_records <= MAXREC_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        REG_LIMIT:  limit <= cfg_data[5:0];
        REG_MAXREC: max_records <= cfg_data;
      endcase
    end
  end

  assign in_ev = {s_tdata[63:0], s_tdata[94:64], s_tdata[126:95], s_tdata[157:127]};
  assign m_tdata = {2'b00, out_ev.trace, out_ev.size, out_ev.stamp, out_ev.address};

  afpe_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_command(s_tuser), .in_ev(in_ev),
    .limit(limit), .clear_fill(clear_fill), .hold(cfg_valid),
    .stopped(stopped), .back_done(back_done), .empty(front_empty),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  afpe_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .max_records(max_records), .busy(back_busy), .stopped(stopped),
    .done(back_done),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_ev(out_ev), .out_last(m_tlast)
  );
endmodule

@@ tb/tb_alloc_free_pair_eliminator_unit.sv @@
// tb_alloc_free_pair_eliminator_unit: stream-level check of the pair eliminator
// predicts kept events per compaction and compares each output word; needs afpe_pkg
`timescale 1ns / 1ps

module tb_alloc_free_pair_eliminator_unit;
  import afpe_pkg::*;

  localparam int DEPTH = 32;

  typedef struct packed {
    logic        cmd;
    logic [63:0] address;
    logic [30:0] stamp;
    logic [31:0] size;
    logic [30:0] trace;
  } evt_word_t;

  typedef struct packed {
    logic [159:0] data;
    logic         last;
  } kept_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [159:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  alloc_free_pair_eliminator_unit #(.BUFFER_DEPTH(DEPTH)) DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [63:0] buf_addr [DEPTH];
  logic [30:0] buf_stamp [DEPTH];
  logic [31:0] buf_size [DEPTH];
  logic [30:0] buf_trace [DEPTH];
  int unsigned fill;
  logic [31:0] emitted;
  bit halted;
  logic [5:0] limit_reg;
  logic [31:0] maxrec_reg;

  evt_word_t pending[$];
  kept_word_t kept_q[$];
  int errors = 0;
  bit quiet_tx = 1'b0;  // no idling stretch
  bit hold_rx = 1'b0;
  bit hold_go = 1'b0;
  bit pause_tx = 1'b0;

  function automatic bit size_pos(logic [31:0] s);
    return s != 0 && !s[31];
  endfunction

  function automatic void compact_buffer();
    int cnt;
    bit first, latest, keep;
    logic [32:0] sum;
    cnt = 0;
    for (int i = 0; i < fill; i++) begin
      first = 1; latest = 1;
      for (int j = 0; j < fill; j++) begin
        if (j != i && buf_addr[j] == buf_addr[i]) begin
          if (j < i) first = 0; else latest = 0;
        end
      end
      keep = (first && latest) || (first && buf_size[i] == FREE_MARK) ||
             (latest && size_pos(buf_size[i]));
      if (keep) begin
        kept_word_t k;
        k.data = {2'b00, buf_trace[i], buf_size[i], buf_stamp[i], buf_addr[i]};
        k.last = 1'b0;
        kept_q.push_back(k);
        cnt++;
      end
    end
    if (cnt > 0) kept_q[$].last = 1'b1;
    sum = {1'b0, emitted} + 33'(cnt);
    emitted = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    fill = 0;
    if (emitted >= maxrec_reg) halted = 1;
  endfunction

  function automatic void predict_event(evt_word_t e);
    int unsigned lim, slot;
    if (e.cmd == CMD_FLUSH) begin
      compact_buffer();
      return;
    end
    if (halted) return;
    slot = (fill >= DEPTH) ? DEPTH - 1 : fill;
    buf_addr[slot] = e.address;
    buf_stamp[slot] = e.stamp;
    buf_size[slot] = e.size;
    buf_trace[slot] = e.trace;
    fill = slot + 1;
    lim = limit_reg == 0 ? 1 : (limit_reg > DEPTH ? DEPTH : limit_reg);
    if (fill >= lim) compact_buffer();
  endfunction

  // accept flag captured on the rising edge
  bit s_tready_seen = 1'b0;
  always @(posedge clk) s_tready_seen <= s_tvalid && s_tready;

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if ((!s_tvalid || s_tready_seen) && pending.size() > 0 && !pause_tx &&
          (quiet_tx || $urandom_range(99) >= 21)) begin
        evt_word_t e;
        e = pending.pop_front();
        predict_event(e);
        s_tdata <= {2'b00, e.trace, e.size, e.stamp, e.address};
        s_tuser <= e.cmd;
        s_tvalid <= 1'b1;
      end else if (s_tvalid && s_tready_seen) begin
        s_tvalid <= 1'b0;
      end
      m_tready <= !hold_rx && (quiet_tx || $urandom_range(99) >= 21);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    hold_rx = 1'b1;
    repeat (600) @(posedge clk);
    hold_rx = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (kept_q.size() == 0) begin
        $display("%0t: unexpected word exp none got data=%h last=%b", $time, m_tdata, m_tlast);
        errors++;
      end else begin
        kept_word_t k;
        k = kept_q.pop_front();
        if (m_tdata[63:0] !== k.data[63:0])
          $display("%0t: address exp %h got %h", $time, k.data[63:0], m_tdata[63:0]);
        if (m_tdata[94:64] !== k.data[94:64])
          $display("%0t: stamp exp %h got %h", $time, k.data[94:64], m_tdata[94:64]);
        if (m_tdata[126:95] !== k.data[126:95])
          $display("%0t: size exp %h got %h", $time, k.data[126:95], m_tdata[126:95]);
        if (m_tdata[157:127] !== k.data[157:127])
          $display("%0t: trace exp %h got %h", $time, k.data[157:127], m_tdata[157:127]);
        if (m_tlast !== k.last)
          $display("%0t: last exp %b got %b", $time, k.last, m_tlast);
        if (m_tdata[157:0] !== k.data[157:0] || m_tlast !== k.last) errors++;
      end
    end
  end

  task automatic wait_drained();
    while (pending.size() > 0 || s_tvalid || kept_q.size() > 0) @(posedge clk);
    repeat (DEPTH * (DEPTH + 3) + 50) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    #1;
    while (!cfg_ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    if (idx == REG_LIMIT) begin
      limit_reg = val[5:0];
      fill = 0;
    end else begin
      maxrec_reg = val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_size();
    int r;
    r = $urandom_range(9);
    if (r < 4) return FREE_MARK;
    if (r == 4) return 32'd0;
    if (r == 5) return 32'h8000_0000 | $urandom;
    if (r == 6) return 32'h7FFF_FFFF;
    return $urandom_range(4096, 1);
  endfunction

  // small address pool so pairs meet inside one buffer load
  function automatic evt_word_t rand_event(int unsigned pool);
    evt_word_t e;
    e.cmd = ($urandom_range(19) == 0) ? CMD_FLUSH : CMD_RECORD;
    e.address = ($urandom_range(15) == 0) ? {$urandom, $urandom}
                                          : 64'hFFFF_0000_0000_0000 + $urandom_range(pool);
    e.stamp = 31'($urandom);
    e.size = rand_size();
    e.trace = 31'($urandom);
    return e;
  endfunction

  function automatic evt_word_t mk(logic c, logic [63:0] a, logic [31:0] s);
    evt_word_t e;
    e.cmd = c; e.address = a; e.stamp = 31'($urandom); e.size = s;
    e.trace = 31'($urandom);
    return e;
  endfunction

  initial begin
    fill = 0; emitted = 0; halted = 0; limit_reg = 32; maxrec_reg = 5000000;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: alloc+free pair, lone events, free first, odd sizes
    write_reg(REG_LIMIT, 32'd8);
    pending.push_back(mk(CMD_RECORD, 64'h0, 32'd16));
    pending.push_back(mk(CMD_RECORD, 64'h0, FREE_MARK));
    pending.push_back(mk(CMD_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF));
    pending.push_back(mk(CMD_RECORD, 64'h10, FREE_MARK));
    pending.push_back(mk(CMD_RECORD, 64'h10, 32'd5));
    pending.push_back(mk(CMD_RECORD, 64'h20, 32'd0));
    pending.push_back(mk(CMD_RECORD, 64'h30, 32'h8000_0000));
    pending.push_back(mk(CMD_RECORD, 64'h30, 32'd0));
    pending.push_back({1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                       31'h7FFF_FFFF});
    pending.push_back(mk(CMD_FLUSH, 64'h0, 32'd0));
    pending.push_back(mk(CMD_RECORD, 64'h40, 32'd1));
    pending.push_back(mk(CMD_FLUSH, 64'h0, 32'd0));
    wait_drained();

    write_reg(REG_LIMIT, 32'd0);
    pending.push_back(mk(CMD_RECORD, 64'h50, 32'd3));
    pending.push_back(mk(CMD_RECORD, 64'h50, FREE_MARK));
    wait_drained();
    write_reg(REG_LIMIT, 32'd63);
    // limit set past the depth cap, so the buffer compacts at 32
    for (int i = 0; i < 40; i++) pending.push_back(rand_event(20));
    wait_drained();

    // random phases with different limits; one long receiver hold-off
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_LIMIT, ph == 0 ? 32'd32 : $urandom_range(1, 32));
      quiet_tx = (ph == 2);
      for (int i = 0; i < 50; i++) pending.push_back(rand_event(ph == 1 ? 4 : 12));
      if (ph == 3) begin
        hold_go = 1'b1;
        @(posedge clk);
        wait (!hold_rx);
      end
      pending.push_back(mk(CMD_FLUSH, 64'h0, 32'd0));
      // sender pauses until all predicted results are received, then resumes
      pause_tx = 1'b1;
      while (kept_q.size() > 0) @(posedge clk);
      pause_tx = 1'b0;
      wait_drained();
    end
    quiet_tx = 1'b0;

    // stop after few records, flush while stopped
    write_reg(REG_LIMIT, 32'd4);
    write_reg(REG_MAXREC, 32'd2);
    for (int i = 0; i < 12; i++) pending.push_back(mk(CMD_RECORD, 64'(i), 32'd9));
    pending.push_back(mk(CMD_FLUSH, 64'h0, 32'd0));
    wait_drained();

    if (errors == 0 && kept_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/afpe_pkg.sv
rtl/core/afpe_front.sv
rtl/core/afpe_back.sv
rtl/core/alloc_free_pair_eliminator_unit.sv
tb/tb_alloc_free_pair_eliminator_unit.sv
